### sv/mcfp_pkg.sv
// mcfp_pkg: shared types and constants for the message coalescing flush policy
// used by the controller, the datapath, the top level and the checker
package mcfp_pkg;

    localparam int DEST_W = 4;
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] THR_RESET = 11'd16;

    typedef enum logic [1:0]
    {
        ACT_FORWARD = 2'd0,
        ACT_QUEUED = 2'd1,
        ACT_FLUSH_QUEUED = 2'd2,
        ACT_STALE = 2'd3
    } act_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEND_EV,
        ST_SCAN_EV,
        ST_SCAN_END
    } state_t;

    typedef struct packed
    {
        logic accept;
        logic eval_send;
        logic eval_scan;
        logic scan_inc;
        logic push_last;
    } cmd_t;

    typedef struct packed
    {
        logic out_free;
        logic stale;
        logic hold_valid;
        logic scan_last;
    } sts_t;

endpackage

### sv/mcfp_ctrl.sv
// mcfp_ctrl: sequencer for sends and progress-tick scans
// depends on mcfp_pkg; drives mcfp_dpath through cmd_t and reads sts_t
module mcfp_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    input  logic            s_opcode,
    output logic            s_ready,
    output mcfp_pkg::cmd_t  cmd,
    input  mcfp_pkg::sts_t  sts
);

    mcfp_pkg::state_t state_reg;
    mcfp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcfp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            mcfp_pkg::ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = s_opcode ? mcfp_pkg::ST_SCAN_EV : mcfp_pkg::ST_SEND_EV;
                end
            end
            mcfp_pkg::ST_SEND_EV:
            begin
                if (sts.out_free)
                begin
                    cmd.eval_send = 1'b1;
                    state_next = mcfp_pkg::ST_IDLE;
                end
            end
            mcfp_pkg::ST_SCAN_EV:
            begin
                // a stale hit pushes the held word out, so it needs room
                if (!(sts.stale && sts.hold_valid && !sts.out_free))
                begin
                    cmd.eval_scan = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = mcfp_pkg::ST_SCAN_END;
                    end
                    else
                    begin
                        cmd.scan_inc = 1'b1;
                    end
                end
            end
            mcfp_pkg::ST_SCAN_END:
            begin
                if (!sts.hold_valid)
                begin
                    state_next = mcfp_pkg::ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.push_last = 1'b1;
                    state_next = mcfp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcfp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/mcfp_dpath.sv
// mcfp_dpath: count memories, threshold register, hold stage and output register
// depends on mcfp_pkg; commanded by mcfp_ctrl
module mcfp_dpath
#(
    parameter int NUM_DEST = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [mcfp_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                           s_opcode,
    input  logic [mcfp_pkg::DEST_W-1:0]    s_dest,
    input  logic                           s_coal,
    input  mcfp_pkg::cmd_t                 cmd,
    output mcfp_pkg::sts_t                 sts,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_act,
    output logic [mcfp_pkg::DEST_W-1:0]    m_node,
    output logic [mcfp_pkg::CNT_W-1:0]     m_cnt,
    output logic                           m_last
);

    localparam int IDX_W = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;
    localparam int DW = mcfp_pkg::DEST_W;
    localparam int CW = mcfp_pkg::CNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DEST - 1);

    logic [CW-1:0]       thr_reg;
    logic [DW-1:0]       dest_reg;
    logic                coal_reg;
    logic [IDX_W-1:0]    scan_reg;
    logic [CW-1:0]       rd_pend_reg;
    logic [CW-1:0]       rd_seen_reg;
    logic [CW-1:0]       pend_mem [NUM_DEST];
    logic [CW-1:0]       seen_mem [NUM_DEST];
    logic [NUM_DEST-1:0] pend_vld_reg;
    logic [NUM_DEST-1:0] seen_vld_reg;
    logic                hold_valid_reg;
    logic [DW-1:0]       hold_node_reg;
    logic [CW-1:0]       hold_cnt_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [1:0]          out_act_reg;
    logic [DW-1:0]       out_node_reg;
    logic [CW-1:0]       out_cnt_reg;
    logic                out_last_reg;

    logic [CW-1:0]       thr_eff;
    logic                in_range;
    logic                qual;
    logic                ge;
    logic [CW-1:0]       new_pend;
    logic                stale;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic                out_free;
    logic                out_load;

    assign thr_eff = (thr_reg == '0) ? CW'(1) : thr_reg;
    assign in_range = (7'(dest_reg) < 7'(NUM_DEST));
    assign qual = coal_reg && in_range;
    assign ge = (rd_pend_reg >= thr_eff);
    assign new_pend = ge ? (rd_pend_reg - thr_eff + CW'(1)) : (rd_pend_reg + CW'(1));
    assign stale = (rd_pend_reg != '0) && (rd_pend_reg == rd_seen_reg);
    assign rd_en = cmd.accept || cmd.scan_inc;
    assign rd_addr = cmd.accept ? (s_opcode ? '0 : IDX_W'(s_dest)) : (scan_reg + IDX_W'(1));
    assign wr_addr = cmd.eval_send ? IDX_W'(dest_reg) : scan_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign out_load = cmd.eval_send || (cmd.eval_scan && stale && hold_valid_reg) || cmd.push_last;
    assign out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    assign sts.out_free = out_free;
    assign sts.stale = stale;
    assign sts.hold_valid = hold_valid_reg;
    assign sts.scan_last = (scan_reg == LAST_IDX);

    assign m_valid = out_valid_reg;
    assign m_act = out_act_reg;
    assign m_node = out_node_reg;
    assign m_cnt = out_cnt_reg;
    assign m_last = out_last_reg;

    // threshold, scan index, valid bits, hold and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= mcfp_pkg::THR_RESET;
            pend_vld_reg <= '0;
            seen_vld_reg <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
            if (cmd.eval_send && qual)
            begin
                pend_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.eval_scan)
            begin
                seen_vld_reg[wr_addr] <= 1'b1;
                if (stale)
                begin
                    pend_vld_reg[wr_addr] <= 1'b0;
                end
            end
            if (cmd.eval_scan && stale)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.push_last)
            begin
                hold_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // count memories
    always_ff @(posedge clk)
    begin
        if (cmd.eval_send && qual)
        begin
            pend_mem[wr_addr] <= new_pend;
        end
        if (cmd.eval_scan)
        begin
            seen_mem[wr_addr] <= stale ? '0 : rd_pend_reg;
        end
        if (rd_en)
        begin
            rd_pend_reg <= pend_vld_reg[rd_addr] ? pend_mem[rd_addr] : '0;
            rd_seen_reg <= seen_vld_reg[rd_addr] ? seen_mem[rd_addr] : '0;
        end
    end

    // input, hold and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dest_reg <= s_dest;
            coal_reg <= s_coal;
        end
        if (cmd.eval_scan && stale)
        begin
            hold_node_reg <= DW'(scan_reg);
            hold_cnt_reg <= rd_pend_reg;
        end
        if (cmd.eval_send)
        begin
            out_node_reg <= dest_reg;
            out_last_reg <= 1'b1;
            if (!qual)
            begin
                out_act_reg <= mcfp_pkg::ACT_FORWARD;
                out_cnt_reg <= '0;
            end
            else if (ge)
            begin
                out_act_reg <= mcfp_pkg::ACT_FLUSH_QUEUED;
                out_cnt_reg <= thr_eff;
            end
            else
            begin
                out_act_reg <= mcfp_pkg::ACT_QUEUED;
                out_cnt_reg <= '0;
            end
        end
        else if ((cmd.eval_scan && stale && hold_valid_reg) || cmd.push_last)
        begin
            out_act_reg <= mcfp_pkg::ACT_STALE;
            out_node_reg <= hold_node_reg;
            out_cnt_reg <= hold_cnt_reg;
            out_last_reg <= cmd.push_last;
        end
    end

endmodule

### sv/message_coalescing_flush_policy.sv
// send: accepted, then evaluated in ST_SEND_EV once the output register is free
// tick: one destination per cycle through the count memory, except while the output
//   stalls with a stale word pending
// one item at a time: ready only while the sequencer is idle
// rst_n (async, active low) clears all counts through per-entry valid bits, threshold 16
module message_coalescing_flush_policy
#(
    parameter int NUM_DEST = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata,      // batch_threshold
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // dest_node[3:0], is_coalescable[4], zero[7:5]
    input  logic        s_axis_tuser,   // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // target_node[3:0], batch_count[14:4], zero[15]
    output logic [1:0]  m_axis_tuser,   // action_code[1:0]
    output logic        m_axis_tlast    // last_of_run
);

    mcfp_pkg::cmd_t cmd;
    mcfp_pkg::sts_t sts;
    logic [mcfp_pkg::DEST_W-1:0] m_node;
    logic [mcfp_pkg::CNT_W-1:0]  m_cnt;

    mcfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_opcode (s_axis_tuser),
        .s_ready  (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mcfp_dpath #(.NUM_DEST(NUM_DEST)) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_opcode  (s_axis_tuser),
        .s_dest    (s_axis_tdata[3:0]),
        .s_coal    (s_axis_tdata[4]),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_act     (m_axis_tuser),
        .m_node    (m_node),
        .m_cnt     (m_cnt),
        .m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, m_cnt, m_node};

endmodule

### sv/mcfp_checker.sv
// mcfp_checker: port-level assertions for message_coalescing_flush_policy
// depends on mcfp_pkg; attached to the top level by the bind below
module mcfp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed under stall");

    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_no_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == mcfp_pkg::ACT_FORWARD
            || m_axis_tuser == mcfp_pkg::ACT_QUEUED) |-> m_axis_tdata[14:4] == 11'd0)
        else $error("nonzero count without flush");

    a_stale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == mcfp_pkg::ACT_STALE |-> m_axis_tdata[14:4] != 11'd0)
        else $error("stale flush of zero count");

    a_send_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != mcfp_pkg::ACT_STALE |-> m_axis_tlast)
        else $error("send word without last");

endmodule

bind message_coalescing_flush_policy mcfp_checker u_mcfp_checker (.*);
